// ===== sv/qrm_pkg.sv =====
package qrm_pkg;

   localparam int FracBitsDefault = 15;
   localparam int NumEntries      = 9;
   localparam int ProdWidth       = 32;
   localparam int NormWidth       = 33;
   localparam int NumerWidth      = 35;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
      logic               zero_error;
   } rsp_type;

   typedef logic [NormWidth-1:0] norm_type;

   typedef struct packed {
      logic     valid;
      logic     zero;
      norm_type norm;
   } front_ctl_type;

endpackage

// ===== sv/quaternion_to_rotation_matrix_core.sv =====
// Channel    Ports                    Timing
// request    start, busy, req_quat    word taken when start is high and busy low
// response   rsp_valid, rsp_matrix    one-cycle strobe, no backpressure
//
// One quaternion enters per cycle; busy is always low.
// Pipeline: product stage, sum stage, one stage per
// quotient bit (FRAC_BITS + 2) in nine parallel divider lanes, output register.
// Reset clears only the valid bits that travel with each word.
module quaternion_to_rotation_matrix_core #(
   parameter int FRAC_BITS = qrm_pkg::FracBitsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  qrm_pkg::req_type  req_quat,
   output logic              rsp_valid,
   output qrm_pkg::rsp_type  rsp_matrix
);
   import qrm_pkg::*;

   localparam int QW = FRAC_BITS + 2;

   front_ctl_type          ctl;
   norm_type               mag [NumEntries];
   logic [NumEntries-1:0]  neg;
   logic [NumEntries-1:0]  lane_vld;
   logic [15:0]            entry [NumEntries];
   logic                   zero_ff [QW];

   logic                   vld_ff;
   rsp_type                rsp_ff;
   logic [15:0]            e_in [NumEntries];
   logic [15:0]            one_in;

   assign busy = 1'b0;

   qrm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .in_quat  (req_quat),
      .out_ctl  (ctl),
      .out_mag  (mag),
      .out_neg  (neg)
   );

   for (genvar i = 0; i < NumEntries; i++) begin : g_lane
      qrm_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (ctl.valid),
         .in_mag    (mag[i]),
         .in_norm   (ctl.norm),
         .in_neg    (neg[i]),
         .out_valid (lane_vld[i]),
         .out_entry (entry[i])
      );
   end

   // carry the zero flag alongside the divider stages
   always_ff @(posedge clock) begin
      zero_ff[0] <= ctl.zero;
      for (int k = 1; k < QW; k++) begin
         zero_ff[k] <= zero_ff[k-1];
      end
   end

   always_comb begin
      one_in = 16'(((QW+1)'(1) << FRAC_BITS) - (QW+1)'(1));
      for (int i = 0; i < NumEntries; i++) begin
         if (zero_ff[QW-1]) begin
            e_in[i] = (i % 4 == 0) ? one_in : 16'd0;
         end else begin
            e_in[i] = entry[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= &lane_vld;
      end
      rsp_ff.m00        <= e_in[0];
      rsp_ff.m01        <= e_in[1];
      rsp_ff.m02        <= e_in[2];
      rsp_ff.m10        <= e_in[3];
      rsp_ff.m11        <= e_in[4];
      rsp_ff.m12        <= e_in[5];
      rsp_ff.m20        <= e_in[6];
      rsp_ff.m21        <= e_in[7];
      rsp_ff.m22        <= e_in[8];
      rsp_ff.zero_error <= zero_ff[QW-1];
   end

   assign rsp_valid  = vld_ff;
   assign rsp_matrix = rsp_ff;

endmodule

// ===== sv/qrm_front.sv =====
module qrm_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  qrm_pkg::req_type           in_quat,
   output qrm_pkg::front_ctl_type     out_ctl,
   output qrm_pkg::norm_type          out_mag [qrm_pkg::NumEntries],
   output logic [qrm_pkg::NumEntries-1:0] out_neg
);
   import qrm_pkg::*;

   typedef logic signed [ProdWidth-1:0]  prod_type;
   typedef logic signed [NumerWidth-1:0] numer_type;

   logic     vld1_ff, zero1_ff;
   prod_type ww_ff, xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;

   logic      vld2_ff, zero2_ff;
   norm_type  norm2_ff;
   norm_type  mag2_ff [NumEntries];
   logic [NumEntries-1:0] neg2_ff;

   numer_type norm_in;
   numer_type numer_in [NumEntries];
   numer_type abs_in [NumEntries];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
      end
      zero1_ff <= (in_quat.quat_w == '0) && (in_quat.quat_x == '0) &&
                  (in_quat.quat_y == '0) && (in_quat.quat_z == '0);
      ww_ff <= ProdWidth'(in_quat.quat_w * in_quat.quat_w);
      xx_ff <= ProdWidth'(in_quat.quat_x * in_quat.quat_x);
      yy_ff <= ProdWidth'(in_quat.quat_y * in_quat.quat_y);
      zz_ff <= ProdWidth'(in_quat.quat_z * in_quat.quat_z);
      xy_ff <= ProdWidth'(in_quat.quat_x * in_quat.quat_y);
      xz_ff <= ProdWidth'(in_quat.quat_x * in_quat.quat_z);
      yz_ff <= ProdWidth'(in_quat.quat_y * in_quat.quat_z);
      wx_ff <= ProdWidth'(in_quat.quat_w * in_quat.quat_x);
      wy_ff <= ProdWidth'(in_quat.quat_w * in_quat.quat_y);
      wz_ff <= ProdWidth'(in_quat.quat_w * in_quat.quat_z);
   end

   function automatic numer_type ext(input prod_type p);
      ext = NumerWidth'(p);
   endfunction

   always_comb begin
      norm_in = ext(ww_ff) + ext(xx_ff) + ext(yy_ff) + ext(zz_ff);
      numer_in[0] = norm_in - ((ext(yy_ff) + ext(zz_ff)) <<< 1);
      numer_in[1] = (ext(xy_ff) + ext(wz_ff)) <<< 1;
      numer_in[2] = (ext(xz_ff) - ext(wy_ff)) <<< 1;
      numer_in[3] = (ext(xy_ff) - ext(wz_ff)) <<< 1;
      numer_in[4] = norm_in - ((ext(xx_ff) + ext(zz_ff)) <<< 1);
      numer_in[5] = (ext(yz_ff) + ext(wx_ff)) <<< 1;
      numer_in[6] = (ext(xz_ff) + ext(wy_ff)) <<< 1;
      numer_in[7] = (ext(yz_ff) - ext(wx_ff)) <<< 1;
      numer_in[8] = norm_in - ((ext(xx_ff) + ext(yy_ff)) <<< 1);
      for (int i = 0; i < NumEntries; i++) begin
         abs_in[i] = numer_in[i][NumerWidth-1] ? -numer_in[i] : numer_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else begin
         vld2_ff <= vld1_ff;
      end
      zero2_ff <= zero1_ff;
      norm2_ff <= norm_in[NormWidth-1:0];
      for (int i = 0; i < NumEntries; i++) begin
         // magnitude never exceeds the norm, so it fits the norm width
         mag2_ff[i] <= abs_in[i][NormWidth-1:0];
         neg2_ff[i] <= numer_in[i][NumerWidth-1];
      end
   end

   assign out_ctl.valid = vld2_ff;
   assign out_ctl.zero  = zero2_ff;
   assign out_ctl.norm  = norm2_ff;
   assign out_mag       = mag2_ff;
   assign out_neg       = neg2_ff;

endmodule

// ===== sv/qrm_div_lane.sv =====
module qrm_div_lane #(
   parameter int FRAC_BITS = qrm_pkg::FracBitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  qrm_pkg::norm_type  in_mag,
   input  qrm_pkg::norm_type  in_norm,
   input  logic               in_neg,
   output logic               out_valid,
   output logic [15:0]        out_entry
);
   import qrm_pkg::*;

   localparam int QW = FRAC_BITS + 2;
   localparam int VW = QW + 17;

   logic              vld_ff  [QW];
   logic              neg_ff  [QW];
   norm_type          norm_ff [QW];
   norm_type          rem_ff  [QW];
   logic [QW-1:0]     quo_ff  [QW];

   logic              ge0_in;

   assign ge0_in = in_mag >= in_norm;

   // integer bit first
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      neg_ff[0]  <= in_neg;
      norm_ff[0] <= in_norm;
      rem_ff[0]  <= ge0_in ? in_mag - in_norm : in_mag;
      quo_ff[0]  <= QW'(ge0_in);
   end

   for (genvar k = 1; k < QW; k++) begin : g_step
      logic [NormWidth:0] sh_in;
      logic [NormWidth:0] diff_in;
      logic               ge_in;

      always_comb begin
         sh_in   = {rem_ff[k-1], 1'b0};
         diff_in = sh_in - {1'b0, norm_ff[k-1]};
         ge_in   = sh_in >= {1'b0, norm_ff[k-1]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_ff[k-1];
         end
         neg_ff[k]  <= neg_ff[k-1];
         norm_ff[k] <= norm_ff[k-1];
         rem_ff[k]  <= ge_in ? diff_in[NormWidth-1:0] : sh_in[NormWidth-1:0];
         quo_ff[k]  <= {quo_ff[k-1][QW-2:0], ge_in};
      end
   end

   logic [QW-1:0]      rnd_in;
   logic signed [VW-1:0] val_in;
   logic signed [VW-1:0] hi_in;
   logic signed [VW-1:0] lo_in;
   logic signed [VW-1:0] sat_in;

   always_comb begin
      // round half away from zero on the magnitude
      rnd_in = QW'((quo_ff[QW-1] + QW'(1)) >> 1);
      val_in = neg_ff[QW-1] ? -VW'(rnd_in) : VW'(rnd_in);
      hi_in  = (VW'(1) <<< FRAC_BITS) - VW'(1);
      lo_in  = -(VW'(1) <<< FRAC_BITS);
      if (val_in > hi_in) begin
         sat_in = hi_in;
      end else if (val_in < lo_in) begin
         sat_in = lo_in;
      end else begin
         sat_in = val_in;
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_entry = sat_in[15:0];

endmodule
